// ----- src/s2dec_pkg.sv -----
// Shared types, constants and digit threshold table for the decimal text converter.
package s2dec_pkg;

   localparam int VALUE_W = 32;
   localparam int CODE_W  = 8;
   localparam int COUNT_W = 4;
   localparam int DIGIT_W = 4;
   localparam int POS_W   = 4;
   localparam int RADIX   = 10;
   localparam int NUM_POS = 10;
   localparam int THR_W   = 34;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   localparam logic [CODE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [POS_W-1:0]  TOP_POS    = POS_W'(NUM_POS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIGN,
      ST_DIGIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit_sign;
      logic digit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_neg;
      logic out_free;
      logic last_pos;
   } sts_type;

   // Entry [p][d] holds d * 10**p.
   typedef logic [NUM_POS-1:0][RADIX-1:0][THR_W-1:0] thresh_type;

   function automatic thresh_type build_thresh();
      thresh_type t;
      logic [THR_W-1:0] p;
      p = THR_W'(1);
      for (int i = 0; i < NUM_POS; i++) begin
         for (int d = 0; d < RADIX; d++) begin
            t[i][d] = THR_W'(p * THR_W'(d));
         end
         p = THR_W'(p * THR_W'(RADIX));
      end
      return t;
   endfunction

   localparam thresh_type THRESH = build_thresh();

endpackage

// ----- src/signed_int_to_decimal_ascii_top.sv -----
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// Input channel req_*: one item per signed 32-bit value in req_tdata.
// Result channel rsp_*: one item per character, most significant first. A
// negative value starts with '-', zero gives a single '0', and no leading
// zeros appear. rsp_tdata carries the character code and the running
// character count of this value; rsp_tlast marks its final character.
// The most negative value gives '-' and ten digits, eleven items in all.
//
// Sequence: an accepted item first loads its magnitude, then emits the sign
// when negative, then steps through each of the ten decimal positions,
// resolved one per cycle while the receiver does not stall, against constant
// multiples of powers of ten, whatever the length of the value. The sign, or
// the top digit of a ten-digit value, is registered by the step after the
// load; leading zero positions emit nothing. The controller takes the next
// item once the last position is stepped, while the final character may
// still wait in the result register.
// When the receiver stalls, the result register holds its character and
// the position sequencer waits with it. Reset empties the result register
// and returns the controller to idle, ready for an item.
module signed_int_to_decimal_ascii_top
   import s2dec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [7:0] char_code, [11:8] char_count, [15:12] zero
   output logic                  rsp_tlast
);

   cmd_type cmd;
   sts_type sts;

   s2dec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   s2dec_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // At most one command reaches the datapath in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.emit_sign, cmd.digit_step}))
      else $error("more than one datapath command at once");

   // A new item is never taken in the cycle after one was accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while an item is in progress");

   // Every character shown is a minus sign or a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] == CHAR_MINUS) ||
                     ((rsp_tdata[7:0] >= CHAR_ZERO) &&
                      (rsp_tdata[7:0] <= CHAR_ZERO + CODE_W'(RADIX - 1))))
      else $error("result character out of range");

   // A minus sign is always the first character and never the last.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[7:0] == CHAR_MINUS) |->
         (rsp_tdata[11:8] == COUNT_W'(1)) && !rsp_tlast)
      else $error("minus sign misplaced");

endmodule

// ----- src/s2dec_ctrl.sv -----
// Controller state machine that sequences the sign and digit steps of one item.
module s2dec_ctrl
   import s2dec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = sts.in_neg ? ST_SIGN : ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (sts.out_free && sts.last_pos) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: a step is issued only when the result register can take a character.
   always_comb begin
      req_tready     = 1'b0;
      cmd.load       = 1'b0;
      cmd.emit_sign  = 1'b0;
      cmd.digit_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SIGN: begin
            cmd.emit_sign = sts.out_free;
         end
         ST_DIGIT: begin
            cmd.digit_step = sts.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/s2dec_dp.sv -----
// Datapath: magnitude, digit extraction by threshold compare, and the result register.
module s2dec_dp
   import s2dec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic [VALUE_W-1:0] mag_ff;
   logic [VALUE_W-1:0] mag_in;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               started_ff;
   logic               started_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic [CODE_W-1:0]  out_code_ff;
   logic [CODE_W-1:0]  out_code_in;
   logic [COUNT_W-1:0] out_count_ff;
   logic [COUNT_W-1:0] out_count_in;
   logic               out_last_ff;
   logic               out_last_in;

   logic [RADIX-1:0]   ge;
   logic [DIGIT_W-1:0] digit;
   logic [THR_W-1:0]   sub_val;
   logic               emit_digit;
   logic               out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   // Status toward the controller.
   assign sts.in_neg   = req_tdata[VALUE_W-1];
   assign sts.out_free = out_free;
   assign sts.last_pos = (pos_ff == '0);

   // Digit at the current position: the largest d with d * 10**pos not above the magnitude.
   always_comb begin
      ge    = '0;
      digit = '0;
      for (int d = 1; d < RADIX; d++) begin
         ge[d] = ({{(THR_W-VALUE_W){1'b0}}, mag_ff} >= THRESH[pos_ff][d]);
      end
      for (int d = 1; d < RADIX; d++) begin
         if (ge[d]) begin
            digit = DIGIT_W'(d);
         end
      end
      sub_val    = THRESH[pos_ff][digit];
      emit_digit = (digit != '0) || started_ff || (pos_ff == '0);
   end

   // Next values of the working registers and the result register.
   always_comb begin
      mag_in       = mag_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      started_in   = started_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_code_in  = out_code_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (cmd.load) begin
         mag_in     = req_tdata[VALUE_W-1] ? VALUE_W'(0) - req_tdata[VALUE_W-1:0]
                                           : req_tdata[VALUE_W-1:0];
         pos_in     = TOP_POS;
         count_in   = '0;
         started_in = 1'b0;
      end else if (cmd.emit_sign) begin
         out_valid_in = 1'b1;
         out_code_in  = CHAR_MINUS;
         out_count_in = count_ff + COUNT_W'(1);
         out_last_in  = 1'b0;
         count_in     = count_ff + COUNT_W'(1);
      end else if (cmd.digit_step) begin
         mag_in     = mag_ff - sub_val[VALUE_W-1:0];
         started_in = started_ff || emit_digit;
         if (pos_ff != '0) begin
            pos_in = pos_ff - POS_W'(1);
         end
         if (emit_digit) begin
            out_valid_in = 1'b1;
            out_code_in  = CHAR_ZERO + {{(CODE_W-DIGIT_W){1'b0}}, digit};
            out_count_in = count_ff + COUNT_W'(1);
            out_last_in  = (pos_ff == '0);
            count_in     = count_ff + COUNT_W'(1);
         end
      end
   end

   // Result valid flag is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      pos_ff       <= pos_in;
      count_ff     <= count_in;
      started_ff   <= started_in;
      out_code_ff  <= out_code_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-CODE_W-COUNT_W){1'b0}}, out_count_ff, out_code_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
